// File: rtl/sspc_pkg.sv
// shared types, codes and constants of the stepper speed-profile controller
package sspc_pkg;

  // widths of rate, delay count, configuration, mode, command, phase and index words
  localparam int unsigned RATE_W  = 16;
  localparam int unsigned DELAY_W = 16;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned MODE_W  = 4;
  localparam int unsigned CMD_W   = 3;
  localparam int unsigned PHASE_W = 4;
  localparam int unsigned CIDX_W  = 3;

  // stream word widths, rounded up to whole bytes
  localparam int unsigned IN_W  = 8;
  localparam int unsigned OUT_W = 32;

  // mode bit positions
  localparam int unsigned MODE_DIR        = 0;
  localparam int unsigned MODE_NO_RELEASE = 1;
  localparam int unsigned MODE_CHK_STOP   = 2;
  localparam int unsigned MODE_CHK_START  = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_START     = 3'd0,
    CMD_STOP      = 3'd1,
    CMD_EMERGENCY = 3'd2,
    CMD_CTRL_TICK = 3'd3,
    CMD_DLY_TICK  = 3'd4,
    CMD_REDUCE_SW = 3'd5,
    CMD_STOP_SW   = 3'd6,
    CMD_NONE      = 3'd7
  } cmd_e;

  typedef enum logic [PHASE_W-1:0] {
    PH_IDLE     = 4'd0,
    PH_ACCEL    = 4'd1,
    PH_CONST    = 4'd2,
    PH_OVERRUN  = 4'd3,
    PH_REDUCE   = 4'd4,
    PH_BREAK    = 4'd5,
    PH_BRAKING  = 4'd6,
    PH_STOPPING = 4'd7,
    PH_STOP     = 4'd8
  } phase_e;

  typedef enum logic [CIDX_W-1:0] {
    CFG_START_PPS  = 3'd0,
    CFG_FIXED_PPS  = 3'd1,
    CFG_ACCEL_STEP = 3'd2,
    CFG_DECEL_STEP = 3'd3,
    CFG_STOP_PPS   = 3'd4,
    CFG_OVER_RUN   = 3'd5,
    CFG_BRAKE_TIME = 3'd6,
    CFG_MODE_BITS  = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [CFG_W-1:0]  start_pps;
    logic [CFG_W-1:0]  fixed_pps;
    logic [CFG_W-1:0]  accel_step;
    logic [CFG_W-1:0]  decel_step;
    logic [CFG_W-1:0]  stop_pps;
    logic [CFG_W-1:0]  over_run_time;
    logic [CFG_W-1:0]  brake_time;
    logic [MODE_W-1:0] mode_bits;
  } cfg_t;

  typedef struct packed {
    cmd_e command;
    logic start_level;
    logic reduce_level;
    logic stop_level;
  } item_t;

  typedef struct packed {
    phase_e             phase;
    logic [RATE_W-1:0]  speed;
    logic [DELAY_W-1:0] delay_count;
    logic               dir;
    logic               error;
  } state_t;

  typedef struct packed {
    logic       brake_pulse;
    logic       release_pulse;
    logic       stable_pulse;
    logic       start_rejected;
  } pulses_t;

endpackage

// File: rtl/sspc_cfg.sv
// configuration register file of the speed-profile controller
module sspc_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [sspc_pkg::CIDX_W-1:0] cfg_index_i,
  input  logic [sspc_pkg::CFG_W-1:0]  cfg_wdata_i,
  output sspc_pkg::cfg_t              cfg_o
);

  sspc_pkg::cfg_t cfg_q;
  sspc_pkg::cfg_t cfg_d;

  // register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (sspc_pkg::cfg_idx_e'(cfg_index_i))
        sspc_pkg::CFG_START_PPS:  cfg_d.start_pps     = cfg_wdata_i;
        sspc_pkg::CFG_FIXED_PPS:  cfg_d.fixed_pps     = cfg_wdata_i;
        sspc_pkg::CFG_ACCEL_STEP: cfg_d.accel_step    = cfg_wdata_i;
        sspc_pkg::CFG_DECEL_STEP: cfg_d.decel_step    = cfg_wdata_i;
        sspc_pkg::CFG_STOP_PPS:   cfg_d.stop_pps      = cfg_wdata_i;
        sspc_pkg::CFG_OVER_RUN:   cfg_d.over_run_time = cfg_wdata_i;
        sspc_pkg::CFG_BRAKE_TIME: cfg_d.brake_time    = cfg_wdata_i;
        sspc_pkg::CFG_MODE_BITS:  cfg_d.mode_bits     = cfg_wdata_i[sspc_pkg::MODE_W-1:0];
        default:                  cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: rtl/sspc_step.sv
// next-state and result logic for one command word
module sspc_step (
  input  sspc_pkg::cfg_t    cfg_i,
  input  sspc_pkg::state_t  state_i,
  input  sspc_pkg::item_t   item_i,
  output sspc_pkg::state_t  state_o,
  output sspc_pkg::pulses_t pulses_o
);

  sspc_pkg::state_t        st;
  sspc_pkg::pulses_t       pl;
  logic [sspc_pkg::RATE_W:0] acc_sum;
  logic                    start_bad;
  logic                    stop_ok;

  // accelerate with saturation
  assign acc_sum = {1'b0, state_i.speed} + {1'b0, cfg_i.accel_step};

  assign start_bad = cfg_i.mode_bits[sspc_pkg::MODE_CHK_START] &&
                     (!item_i.start_level || item_i.reduce_level || item_i.stop_level);

  // ramp down continues only above both step and stop rate
  assign stop_ok = (cfg_i.decel_step != '0) && (state_i.speed > cfg_i.decel_step) &&
                   (state_i.speed > cfg_i.stop_pps);

  always_comb begin
    st = state_i;
    pl = '0;
    unique case (item_i.command)
      sspc_pkg::CMD_START: begin
        if (start_bad) begin
          pl.start_rejected = 1'b1;
        end else begin
          st.dir = cfg_i.mode_bits[sspc_pkg::MODE_DIR];
          if (cfg_i.accel_step != '0) begin
            st.speed = cfg_i.start_pps;
            st.phase = sspc_pkg::PH_ACCEL;
          end else begin
            st.speed = cfg_i.fixed_pps;
            st.phase = sspc_pkg::PH_CONST;
          end
          st.delay_count = '0;
          st.error       = 1'b0;
        end
      end
      sspc_pkg::CMD_STOP: begin
        if (state_i.phase != sspc_pkg::PH_IDLE) begin
          if (cfg_i.over_run_time != '0) begin
            st.delay_count = cfg_i.over_run_time;
            st.phase       = sspc_pkg::PH_OVERRUN;
          end else begin
            st.phase = sspc_pkg::PH_REDUCE;
          end
        end
      end
      sspc_pkg::CMD_EMERGENCY: begin
        st.phase = sspc_pkg::PH_BREAK;
      end
      sspc_pkg::CMD_CTRL_TICK: begin
        // ramp step
        if (state_i.phase == sspc_pkg::PH_ACCEL) begin
          if (state_i.speed >= cfg_i.fixed_pps) begin
            st.speed        = cfg_i.fixed_pps;
            st.phase        = sspc_pkg::PH_CONST;
            pl.stable_pulse = 1'b1;
          end else if (acc_sum[sspc_pkg::RATE_W]) begin
            st.speed = '1;
          end else begin
            st.speed = acc_sum[sspc_pkg::RATE_W-1:0];
          end
        end else if (state_i.phase == sspc_pkg::PH_REDUCE) begin
          if (stop_ok) begin
            st.speed = state_i.speed - cfg_i.decel_step;
          end else begin
            st.speed = '0;
            st.phase = sspc_pkg::PH_BREAK;
          end
        end
        // apply the brake
        if (st.phase == sspc_pkg::PH_BREAK) begin
          pl.brake_pulse = 1'b1;
          st.speed       = '0;
          if (cfg_i.brake_time != '0) begin
            st.delay_count = cfg_i.brake_time;
            st.phase       = sspc_pkg::PH_BRAKING;
          end else begin
            st.phase = sspc_pkg::PH_STOPPING;
          end
        end
        // release coils and check the stop sensor
        if (st.phase == sspc_pkg::PH_STOPPING) begin
          pl.release_pulse = !cfg_i.mode_bits[sspc_pkg::MODE_NO_RELEASE];
          st.phase         = sspc_pkg::PH_STOP;
          if (cfg_i.mode_bits[sspc_pkg::MODE_CHK_STOP] && !item_i.stop_level) begin
            st.error = 1'b1;
          end
        end
      end
      sspc_pkg::CMD_DLY_TICK: begin
        if (state_i.delay_count != '0) begin
          st.delay_count = state_i.delay_count - 1'b1;
          if (st.delay_count == '0) begin
            if (state_i.phase == sspc_pkg::PH_OVERRUN) begin
              st.phase = sspc_pkg::PH_REDUCE;
            end else if (state_i.phase == sspc_pkg::PH_BRAKING) begin
              st.phase = sspc_pkg::PH_STOPPING;
            end
          end
        end
      end
      sspc_pkg::CMD_REDUCE_SW: begin
        if (state_i.phase != sspc_pkg::PH_IDLE && state_i.phase < sspc_pkg::PH_REDUCE &&
            item_i.reduce_level) begin
          if (cfg_i.over_run_time != '0) begin
            st.delay_count = cfg_i.over_run_time;
            st.phase       = sspc_pkg::PH_OVERRUN;
          end else begin
            st.phase = sspc_pkg::PH_REDUCE;
          end
        end
      end
      sspc_pkg::CMD_STOP_SW: begin
        if (state_i.phase != sspc_pkg::PH_IDLE && state_i.phase < sspc_pkg::PH_BREAK &&
            item_i.stop_level) begin
          st.phase = sspc_pkg::PH_BREAK;
        end
      end
      default: begin
        st = state_i;
      end
    endcase
  end

  assign state_o  = st;
  assign pulses_o = pl;

endmodule

// File: rtl/stepper_speed_profile_controller_unit.sv
// top level of the stepper speed-profile controller
// Command words are taken one per clock cycle, back to back, while the result side
// does not stall. An accepted word is held in an input register, passes the single step
// stage (a 16-bit add, a subtract and a few compares) and lands in the output register,
// from which its result word is offered; that one step stage sets the rate of one word
// per cycle. While a result word waits, the input register still takes one more word
// and then holds the input off.
// Every command word yields exactly one result word. Configuration writes take effect
// at the next clock edge and are meant to be made only while no word is in flight.
module stepper_speed_profile_controller_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration write port
  input  logic                        cfg_we_i,
  input  logic [sspc_pkg::CIDX_W-1:0] cfg_index_i,
  input  logic [sspc_pkg::CFG_W-1:0]  cfg_wdata_i,
  // command stream
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // command[2:0], start_level[3], reduce_level[4], stop_level[5], zero[7:6]
  input  logic [sspc_pkg::IN_W-1:0]   s_axis_tdata,
  // result stream
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // pps[15:0], phase[19:16], direction[20], brake_pulse[21], release_pulse[22],
  // stable_pulse[23], start_rejected[24], stop_error[25], zero[31:26]
  output logic [sspc_pkg::OUT_W-1:0]  m_axis_tdata
);

  sspc_pkg::cfg_t    cfg;
  sspc_pkg::item_t   in_item_q;
  sspc_pkg::item_t   in_item_d;
  logic              in_valid_q;
  sspc_pkg::state_t  state_q;
  sspc_pkg::state_t  state_d;
  sspc_pkg::pulses_t pulses;
  logic [sspc_pkg::OUT_W-1:0] out_data_q;
  logic [sspc_pkg::OUT_W-1:0] out_data_d;
  logic              out_valid_q;
  logic              s_accept;
  logic              advance;

  sspc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  sspc_step u_step (
    .cfg_i    (cfg),
    .state_i  (state_q),
    .item_i   (in_item_q),
    .state_o  (state_d),
    .pulses_o (pulses)
  );

  // handshake: the input word moves on when the output register is free or being emptied
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  // unpack the command word
  assign in_item_d.command      = sspc_pkg::cmd_e'(s_axis_tdata[sspc_pkg::CMD_W-1:0]);
  assign in_item_d.start_level  = s_axis_tdata[3];
  assign in_item_d.reduce_level = s_axis_tdata[4];
  assign in_item_d.stop_level   = s_axis_tdata[5];

  // pack the result word
  assign out_data_d = {6'd0, state_d.error, pulses.start_rejected, pulses.stable_pulse,
                       pulses.release_pulse, pulses.brake_pulse, state_d.dir,
                       state_d.phase, state_d.speed};

  // valid flags and profile state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '{phase: sspc_pkg::PH_IDLE, default: '0};
    end else begin
      if (s_accept) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        state_q     <= state_d;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_item_q <= in_item_d;
    end
    if (advance) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// File: rtl/sspc_checker.sv
// port-level checks of the speed-profile controller and their binding
module sspc_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       s_axis_tvalid,
  input logic                       s_axis_tready,
  input logic [sspc_pkg::IN_W-1:0]  s_axis_tdata,
  input logic                       m_axis_tvalid,
  input logic                       m_axis_tready,
  input logic [sspc_pkg::OUT_W-1:0] m_axis_tdata
);

  logic [sspc_pkg::PHASE_W-1:0] phase_f;
  logic                         in_seen;

  assign phase_f = m_axis_tdata[19:16];
  assign in_seen = s_axis_tvalid && s_axis_tready && (s_axis_tdata[7:6] == 2'b00);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  // a brake leaves the rate at zero in braking or stop
  a_brake: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[21] |->
      m_axis_tdata[15:0] == '0 &&
      (phase_f == sspc_pkg::PH_BRAKING || phase_f == sspc_pkg::PH_STOP))
    else $error("brake without zero rate or braking phase");

  // release only ends in the stop phase
  a_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[22] |-> phase_f == sspc_pkg::PH_STOP)
    else $error("release outside stop phase");

  // stable pulse only on entry to constant speed, never with a brake or a rejected start
  a_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[23] |->
      phase_f == sspc_pkg::PH_CONST && !m_axis_tdata[21] && !m_axis_tdata[24])
    else $error("stable pulse outside constant phase");

  // an accepted word is always answered when no result word was offered at acceptance
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_seen && !m_axis_tvalid |=> ##1 m_axis_tvalid)
    else $error("result word missing after accepted command word");

endmodule

bind stepper_speed_profile_controller_unit sspc_checker u_sspc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// File: tb/tb_stepper_speed_profile_controller_unit.sv
`timescale 1ns / 100ps
// testbench for the stepper speed-profile controller: phase-steered command words, predicted results
module tb_stepper_speed_profile_controller_unit;
  import sspc_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 500000;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned RANDOM_WORDS  = 1150;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned MAX_PRINTS    = 40;

  // result word, fields from the top bit down
  typedef struct packed {
    logic [5:0]         pad;
    logic               stop_error;
    logic               start_rejected;
    logic               stable_pulse;
    logic               rel_pulse;
    logic               brake_pulse;
    logic               direction;
    logic [PHASE_W-1:0] phase;
    logic [RATE_W-1:0]  pps;
  } profile_word_t;

  // tracks the speed profile and holds the result words still due
  class speed_profile_tracker;
    cfg_t               regs;
    phase_e             ph;
    logic [RATE_W-1:0]  speed;
    logic [DELAY_W-1:0] dly;
    logic               dir;
    logic               err;
    profile_word_t      due_words[$];
    int unsigned        errors;
    int unsigned        n_cmds;
    int unsigned        n_checked;
    int unsigned        n_stable;
    int unsigned        n_brakes;
    int unsigned        n_rejects;
    int unsigned        n_stop_errs;

    function new();
      regs        = '0;
      ph          = PH_IDLE;
      speed       = '0;
      dly         = '0;
      dir         = 1'b0;
      err         = 1'b0;
      errors      = 0;
      n_cmds      = 0;
      n_checked   = 0;
      n_stable    = 0;
      n_brakes    = 0;
      n_rejects   = 0;
      n_stop_errs = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [CFG_W-1:0] val);
      case (idx)
        CFG_START_PPS:  regs.start_pps     = val;
        CFG_FIXED_PPS:  regs.fixed_pps     = val;
        CFG_ACCEL_STEP: regs.accel_step    = val;
        CFG_DECEL_STEP: regs.decel_step    = val;
        CFG_STOP_PPS:   regs.stop_pps      = val;
        CFG_OVER_RUN:   regs.over_run_time = val;
        CFG_BRAKE_TIME: regs.brake_time    = val;
        CFG_MODE_BITS:  regs.mode_bits     = val[MODE_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return due_words.size();
    endfunction

    // stop request: optional over-run first, then ramp down
    function void start_ramp_down();
      if (ph == PH_IDLE) return;
      if (regs.over_run_time != 0) begin
        dly = regs.over_run_time;
        ph  = PH_OVERRUN;
      end else begin
        ph = PH_REDUCE;
      end
    endfunction

    function void note_command(item_t it);
      profile_word_t    w;
      logic [RATE_W:0]  sum;
      w = '0;
      n_cmds++;
      case (it.command)
        CMD_START: begin
          if (regs.mode_bits[MODE_CHK_START] &&
              (!it.start_level || it.reduce_level || it.stop_level)) begin
            w.start_rejected = 1'b1;
          end else begin
            dir = regs.mode_bits[MODE_DIR];
            if (regs.accel_step != 0) begin
              speed = regs.start_pps;
              ph    = PH_ACCEL;
            end else begin
              speed = regs.fixed_pps;
              ph    = PH_CONST;
            end
            dly = '0;
            err = 1'b0;
          end
        end
        CMD_STOP:      start_ramp_down();
        CMD_EMERGENCY: ph = PH_BREAK;
        CMD_CTRL_TICK: begin
          // ramp up with saturation, or ramp down towards the stop rate
          if (ph == PH_ACCEL) begin
            if (speed >= regs.fixed_pps) begin
              speed          = regs.fixed_pps;
              ph             = PH_CONST;
              w.stable_pulse = 1'b1;
            end else begin
              sum   = {1'b0, speed} + {1'b0, regs.accel_step};
              speed = sum[RATE_W] ? '1 : sum[RATE_W-1:0];
            end
          end else if (ph == PH_REDUCE) begin
            if (regs.decel_step != 0 && speed > regs.decel_step && speed > regs.stop_pps) begin
              speed = speed - regs.decel_step;
            end else begin
              speed = '0;
              ph    = PH_BREAK;
            end
          end
          // brake falls through to stopping in the same tick when no hold time
          if (ph == PH_BREAK) begin
            w.brake_pulse = 1'b1;
            speed         = '0;
            if (regs.brake_time != 0) begin
              dly = regs.brake_time;
              ph  = PH_BRAKING;
            end else begin
              ph = PH_STOPPING;
            end
          end
          if (ph == PH_STOPPING) begin
            if (!regs.mode_bits[MODE_NO_RELEASE]) w.rel_pulse = 1'b1;
            ph = PH_STOP;
            if (regs.mode_bits[MODE_CHK_STOP] && !it.stop_level) err = 1'b1;
          end
        end
        CMD_DLY_TICK: begin
          if (dly != 0) begin
            dly = dly - 1'b1;
            if (dly == 0) begin
              if (ph == PH_OVERRUN) ph = PH_REDUCE;
              else if (ph == PH_BRAKING) ph = PH_STOPPING;
            end
          end
        end
        CMD_REDUCE_SW: begin
          if (ph != PH_IDLE && ph < PH_REDUCE && it.reduce_level) start_ramp_down();
        end
        CMD_STOP_SW: begin
          if (ph != PH_IDLE && ph < PH_BREAK && it.stop_level) ph = PH_BREAK;
        end
        default: ;
      endcase
      w.pps        = speed;
      w.phase      = ph;
      w.direction  = dir;
      w.stop_error = err;
      if (w.stable_pulse) n_stable++;
      if (w.brake_pulse) n_brakes++;
      if (w.start_rejected) n_rejects++;
      if (w.stop_error) n_stop_errs++;
      due_words.push_back(w);
    endfunction

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      if (errors <= MAX_PRINTS)
        $display("mismatch on %s at result %0d: got %0h, want %0h", what, n_checked, got, want);
    endtask

    task check_word(logic [OUT_W-1:0] data);
      profile_word_t got;
      profile_word_t want;
      got = data;
      n_checked++;
      if (due_words.size() == 0) begin
        report_mismatch("unexpected result word", data, 0);
        return;
      end
      want = due_words.pop_front();
      if (got.pps !== want.pps) report_mismatch("pps", got.pps, want.pps);
      if (got.phase !== want.phase) report_mismatch("phase", got.phase, want.phase);
      if (got.direction !== want.direction)
        report_mismatch("direction", got.direction, want.direction);
      if (got.brake_pulse !== want.brake_pulse)
        report_mismatch("brake_pulse", got.brake_pulse, want.brake_pulse);
      if (got.rel_pulse !== want.rel_pulse)
        report_mismatch("release_pulse", got.rel_pulse, want.rel_pulse);
      if (got.stable_pulse !== want.stable_pulse)
        report_mismatch("stable_pulse", got.stable_pulse, want.stable_pulse);
      if (got.start_rejected !== want.start_rejected)
        report_mismatch("start_rejected", got.start_rejected, want.start_rejected);
      if (got.stop_error !== want.stop_error)
        report_mismatch("stop_error", got.stop_error, want.stop_error);
      if (got.pad !== want.pad) report_mismatch("padding", got.pad, want.pad);
    endtask
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CIDX_W-1:0]   cfg_index_i;
  logic [CFG_W-1:0]    cfg_wdata_i;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  // command[2:0], start_level[3], reduce_level[4], stop_level[5], zero[7:6]
  logic [IN_W-1:0]     s_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  // pps[15:0], phase[19:16], direction[20], brake_pulse[21], release_pulse[22],
  // stable_pulse[23], start_rejected[24], stop_error[25], zero[31:26]
  logic [OUT_W-1:0]    m_axis_tdata;

  speed_profile_tracker tracker = new();
  bit                   src_steady   = 1'b0;
  bit                   sink_steady  = 1'b0;
  bit                   sink_holding = 1'b0;
  bit                   hold_req     = 1'b0;
  int unsigned          cycle_count  = 0;
  int unsigned          n_settings   = 0;

  stepper_speed_profile_controller_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // write the registers picked by mask, back to back; mode gets random upper bits
  task automatic write_regs(cfg_t c, logic [7:0] mask);
    logic [CFG_W-1:0] val;
    cfg_idx_e         idx;
    for (int i = 0; i < 8; i++) begin
      if (mask[i]) begin
        idx = cfg_idx_e'(i);
        case (idx)
          CFG_START_PPS:  val = c.start_pps;
          CFG_FIXED_PPS:  val = c.fixed_pps;
          CFG_ACCEL_STEP: val = c.accel_step;
          CFG_DECEL_STEP: val = c.decel_step;
          CFG_STOP_PPS:   val = c.stop_pps;
          CFG_OVER_RUN:   val = c.over_run_time;
          CFG_BRAKE_TIME: val = c.brake_time;
          default:        val = {12'($urandom), c.mode_bits};
        endcase
        cfg_we_i    <= 1'b1;
        cfg_index_i <= idx;
        cfg_wdata_i <= val;
        tracker.set_reg(idx, val);
        @(posedge clk_i);
      end
    end
    cfg_we_i <= 1'b0;
    n_settings++;
  endtask

  // offer one command word after a random gap and wait for it to be taken
  task automatic send_word(item_t it);
    int unsigned gap;
    gap = (src_steady || sink_holding) ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, it.stop_level, it.reduce_level, it.start_level, it.command};
    do @(posedge clk_i); while (!s_axis_tready);
    tracker.note_command(it);
  endtask

  task automatic send_cmd(cmd_e c, logic st, logic rd, logic sp);
    item_t it;
    it.command      = c;
    it.start_level  = st;
    it.reduce_level = rd;
    it.stop_level   = sp;
    send_word(it);
  endtask

  // let every due result come back before touching the registers
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [CFG_W-1:0] pick_rate(int unsigned lo, int unsigned hi);
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return 16'($urandom);
      default: return 16'($urandom_range(lo, hi));
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_delay();
    case ($urandom_range(0, 9))
      0, 1, 2: return '0;
      3:       return '1;
      default: return 16'($urandom_range(1, 6));
    endcase
  endfunction

  function automatic cfg_t random_regs();
    cfg_t c;
    c.start_pps     = pick_rate(0, 2000);
    c.fixed_pps     = pick_rate(0, 4000);
    c.accel_step    = pick_rate(50, 1000);
    c.decel_step    = pick_rate(50, 1000);
    c.stop_pps      = pick_rate(0, 800);
    c.over_run_time = pick_delay();
    c.brake_time    = pick_delay();
    c.mode_bits     = 4'($urandom);
    return c;
  endfunction

  // mostly commands that move the current phase on, some noise
  function automatic item_t next_command(phase_e ph);
    item_t       it;
    int unsigned roll;
    it.command      = CMD_CTRL_TICK;
    it.start_level  = 1'($urandom);
    it.reduce_level = 1'($urandom);
    it.stop_level   = 1'($urandom);
    if ($urandom_range(0, 99) < 15) begin
      it.command = cmd_e'($urandom_range(0, 7));
      return it;
    end
    roll = $urandom_range(0, 99);
    case (ph)
      PH_IDLE, PH_STOP: begin
        if (ph == PH_STOP && roll < 10) begin
          it.command = CMD_STOP;
        end else begin
          it.command = CMD_START;
          if (roll < 85) begin
            it.start_level  = 1'b1;
            it.reduce_level = 1'b0;
            it.stop_level   = 1'b0;
          end
        end
      end
      PH_ACCEL: begin
        if (roll < 80) it.command = CMD_CTRL_TICK;
        else if (roll < 88) it.command = CMD_STOP;
        else if (roll < 94) begin
          it.command      = CMD_REDUCE_SW;
          it.reduce_level = 1'b1;
        end else begin
          it.command    = CMD_STOP_SW;
          it.stop_level = 1'b1;
        end
      end
      PH_CONST: begin
        if (roll < 35) it.command = CMD_CTRL_TICK;
        else if (roll < 55) it.command = CMD_STOP;
        else if (roll < 70) begin
          it.command      = CMD_REDUCE_SW;
          it.reduce_level = 1'b1;
        end else if (roll < 82) begin
          it.command    = CMD_STOP_SW;
          it.stop_level = 1'b1;
        end else if (roll < 90) it.command = CMD_EMERGENCY;
        else it.command = CMD_DLY_TICK;
      end
      PH_OVERRUN, PH_BRAKING: it.command = (roll < 85) ? CMD_DLY_TICK : CMD_CTRL_TICK;
      default: it.command = CMD_CTRL_TICK;
    endcase
    return it;
  endfunction

  // result side: random stalls, one long hold-off on request
  initial begin
    int unsigned stall;
    m_axis_tready <= 1'b0;
    @(posedge clk_i);
    wait (rst_ni);
    forever begin
      if ($urandom_range(0, 39) == 0) sink_steady = !sink_steady;
      if (hold_req) begin
        hold_req      = 1'b0;
        sink_holding  = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        sink_holding = 1'b0;
      end else begin
        stall = sink_steady ? 0 : $urandom_range(0, 14);
        if (stall > 0) begin
          m_axis_tready <= 1'b0;
          repeat (stall) @(posedge clk_i);
        end
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      tracker.check_word(m_axis_tdata);
    end
  end

  // stimulus
  initial begin
    cfg_t        c;
    int unsigned sent;
    int unsigned len;
    bit          hold_armed;
    sent          = 0;
    hold_armed    = 1'b0;
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_index_i   <= CFG_START_PPS;
    cfg_wdata_i   <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // full profile: ramp up, over-run, ramp down, brake hold, release, stop sensor error
    c = '{start_pps: 16'd100, fixed_pps: 16'd400, accel_step: 16'd150, decel_step: 16'd100,
          stop_pps: 16'd50, over_run_time: 16'd2, brake_time: 16'd2, mode_bits: 4'b0101};
    write_regs(c, 8'hFF);
    send_cmd(CMD_STOP, 1'b0, 1'b0, 1'b0);
    send_cmd(CMD_REDUCE_SW, 1'b0, 1'b1, 1'b0);
    send_cmd(CMD_DLY_TICK, 1'b0, 1'b0, 1'b0);
    send_cmd(CMD_NONE, 1'b1, 1'b1, 1'b1);
    send_cmd(CMD_START, 1'b1, 1'b0, 1'b0);
    repeat (3) send_cmd(CMD_CTRL_TICK, 1'b0, 1'b0, 1'b1);
    send_cmd(CMD_REDUCE_SW, 1'b0, 1'b0, 1'b0);
    send_cmd(CMD_REDUCE_SW, 1'b0, 1'b1, 1'b0);
    repeat (2) send_cmd(CMD_DLY_TICK, 1'b0, 1'b0, 1'b0);
    repeat (4) send_cmd(CMD_CTRL_TICK, 1'b0, 1'b0, 1'b1);
    repeat (2) send_cmd(CMD_DLY_TICK, 1'b0, 1'b0, 1'b0);
    send_cmd(CMD_CTRL_TICK, 1'b0, 1'b0, 1'b0);
    send_cmd(CMD_STOP, 1'b0, 1'b0, 1'b0);
    send_cmd(CMD_EMERGENCY, 1'b0, 1'b0, 1'b0);
    send_cmd(CMD_CTRL_TICK, 1'b0, 1'b0, 1'b1);
    drain();

    // extremes: rejected starts, rate saturation, no release, zero decel
    c = '{start_pps: 16'hFF00, fixed_pps: 16'hFFFF, accel_step: 16'hFFFF, decel_step: 16'h0,
          stop_pps: 16'hFFFF, over_run_time: 16'h0, brake_time: 16'h0, mode_bits: 4'b1010};
    write_regs(c, 8'hFF);
    send_cmd(CMD_START, 1'b0, 1'b0, 1'b0);
    send_cmd(CMD_START, 1'b1, 1'b1, 1'b0);
    send_cmd(CMD_START, 1'b1, 1'b0, 1'b1);
    send_cmd(CMD_START, 1'b1, 1'b0, 1'b0);
    repeat (2) send_cmd(CMD_CTRL_TICK, 1'b0, 1'b0, 1'b0);
    send_cmd(CMD_STOP_SW, 1'b0, 1'b0, 1'b1);
    send_cmd(CMD_CTRL_TICK, 1'b0, 1'b0, 1'b0);
    send_cmd(CMD_STOP, 1'b0, 1'b0, 1'b0);
    send_cmd(CMD_CTRL_TICK, 1'b0, 1'b0, 1'b0);
    drain();

    // random settings, each followed by a run of phase-steered words
    while (sent < RANDOM_WORDS) begin
      write_regs(random_regs(), (n_settings == 2) ? 8'hFF : 8'($urandom));
      src_steady = ($urandom_range(0, 3) == 0);
      len = $urandom_range(15, 60);
      if (!hold_armed && sent >= 300) begin
        hold_armed = 1'b1;
        hold_req   = 1'b1;
        len        = 80;
      end
      repeat (len) begin
        send_word(next_command(tracker.ph));
        sent++;
      end
      drain();
    end
    repeat (8) @(posedge clk_i);

    $display("run covered %0d command words over %0d register settings, %0d results checked",
             tracker.n_cmds, n_settings, tracker.n_checked);
    $display("profile events: %0d stable, %0d brakes, %0d rejected starts, %0d with stop error",
             tracker.n_stable, tracker.n_brakes, tracker.n_rejects, tracker.n_stop_errs);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
